>>> hw/rtl/vpa_pkg.sv
package vpa_pkg;

  // width of the squared offset, Q20
  localparam int unsigned XW = 31;
  // width of the gaussian term and of the result, Q24
  localparam int unsigned GW = 24;
  // divider remainder width and quotient widths
  localparam int unsigned DIV_DW  = 31;
  localparam int unsigned DIV_QW1 = 29;
  localparam int unsigned DIV_QW2 = 28;
  // depth of the gaussian term pipeline
  localparam int unsigned GAUSS_LAT = 23;

endpackage

>>> hw/rtl/vpa_div.sv
module vpa_div #(
  parameter int unsigned DW = vpa_pkg::DIV_DW,
  parameter int unsigned QW = vpa_pkg::DIV_QW1,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // one quotient bit per stage, restoring division
  logic [DW-1:0] rem_q  [QW-1];
  logic [DW-1:0] den_q  [QW-1];
  logic [QW-1:0] ql_q   [QW];
  logic [SW-1:0] side_q [QW];

  logic [DW-1:0] rem_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [QW-1:0] ql_in  [QW];
  logic [DW:0]   trial  [QW];
  logic [DW:0]   diff   [QW];
  logic          ge     [QW];
  logic [DW-1:0] rem_d  [QW];
  logic [QW-1:0] ql_d   [QW];

  // stage inputs and trial subtraction
  always_comb begin
    rem_in[0] = rem_i;
    den_in[0] = den_i;
    ql_in[0]  = low_i;
    for (int i = 1; i < QW; i++) begin
      rem_in[i] = rem_q[i-1];
      den_in[i] = den_q[i-1];
      ql_in[i]  = ql_q[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      trial[i] = {rem_in[i], ql_in[i][QW-1]};
      ge[i]    = trial[i] >= {1'b0, den_in[i]};
      diff[i]  = trial[i] - {1'b0, den_in[i]};
      rem_d[i] = ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
      ql_d[i]  = {ql_in[i][QW-2:0], ge[i]};
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW - 1; i++) begin
        rem_q[i] <= rem_d[i];
        den_q[i] <= den_in[i];
      end
      for (int i = 0; i < QW; i++) begin
        ql_q[i] <= ql_d[i];
      end
      side_q[0] <= side_i;
      for (int i = 1; i < QW; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign quo_o  = ql_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

>>> hw/rtl/vpa_gauss.sv
module vpa_gauss #(
  parameter int unsigned SW = 1
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [vpa_pkg::XW-1:0]  x_i,
  input  logic [SW-1:0]           side_i,
  output logic [vpa_pkg::GW-1:0]  gauss_o,
  output logic [SW-1:0]           side_o
);

  localparam int unsigned NSTEP = 8;
  localparam int unsigned NSQ   = 6;
  localparam logic [31:0] ONE31 = 32'h8000_0000;
  localparam logic [30:0] INV_SQRTPI31 = 31'd1211587905;
  localparam logic [vpa_pkg::XW-1:0] GAUSS_LIMIT = 31'd18874368;
  // reciprocals for division by 8 down to 1, exact for 30-bit dividends
  localparam logic [31:0] RECIP [NSTEP] = '{
    32'd1073741824, 32'd1227133514, 32'd1431655766, 32'd1717986919,
    32'd1073741824, 32'd1431655766, 32'd1073741824, 32'd1073741824
  };
  localparam int unsigned RSHIFT [NSTEP] = '{33, 33, 33, 33, 32, 32, 31, 30};

  typedef struct packed {
    logic [29:0]   r;
    logic          big;
    logic [SW-1:0] side;
  } carry_t;

  carry_t      entry_c;
  carry_t      ha_c_q [NSTEP];
  logic [29:0] ha_p_q [NSTEP];
  carry_t      hb_c_q [NSTEP];
  logic [31:0] hb_t_q [NSTEP];
  carry_t      sq_c_q [NSQ];
  logic [31:0] sq_t_q [NSQ];
  logic [vpa_pkg::GW-1:0] out_q;
  logic [SW-1:0]          out_side_q;

  carry_t      h_c_in [NSTEP];
  logic [31:0] h_t_in [NSTEP];
  logic [61:0] prod_p [NSTEP];
  logic [61:0] prod_d [NSTEP];
  logic [31:0] quot   [NSTEP];
  logic [31:0] s_t_in [NSQ];
  logic [63:0] prod_s [NSQ];
  logic [62:0] prod_g;

  // scaled argument, zero term beyond the range
  always_comb begin
    entry_c.r    = {x_i[24:0], 5'b0};
    entry_c.big  = x_i >= GAUSS_LIMIT;
    entry_c.side = side_i;
  end

  // horner steps of the truncated series, repeated squaring, then scaling by 1/sqrt(pi)
  always_comb begin
    h_c_in[0] = entry_c;
    h_t_in[0] = ONE31;
    for (int h = 1; h < NSTEP; h++) begin
      h_c_in[h] = hb_c_q[h-1];
      h_t_in[h] = hb_t_q[h-1];
    end
    for (int h = 0; h < NSTEP; h++) begin
      prod_p[h] = 62'(h_c_in[h].r) * 62'(h_t_in[h]);
      prod_d[h] = 62'(ha_p_q[h]) * 62'(RECIP[h]);
      quot[h]   = 32'(prod_d[h] >> RSHIFT[h]);
    end
    s_t_in[0] = hb_t_q[NSTEP-1];
    for (int s = 1; s < NSQ; s++) begin
      s_t_in[s] = sq_t_q[s-1];
    end
    for (int s = 0; s < NSQ; s++) begin
      prod_s[s] = 64'(s_t_in[s]) * 64'(s_t_in[s]);
    end
    prod_g = 63'(sq_t_q[NSQ-1]) * 63'(INV_SQRTPI31);
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int h = 0; h < NSTEP; h++) begin
        ha_c_q[h] <= h_c_in[h];
        ha_p_q[h] <= prod_p[h][60:31];
        hb_c_q[h] <= ha_c_q[h];
        hb_t_q[h] <= ONE31 - quot[h];
      end
      sq_c_q[0] <= hb_c_q[NSTEP-1];
      for (int s = 1; s < NSQ; s++) begin
        sq_c_q[s] <= sq_c_q[s-1];
      end
      for (int s = 0; s < NSQ; s++) begin
        sq_t_q[s] <= prod_s[s][62:31];
      end
      out_q      <= sq_c_q[NSQ-1].big ? '0 : prod_g[61:38];
      out_side_q <= sq_c_q[NSQ-1].side;
    end
  end

  assign gauss_o = out_q;
  assign side_o  = out_side_q;

endmodule

>>> hw/rtl/voigt_profile_approx_unit.sv
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined dividers
// (one quotient bit per stage) and the gaussian series pipeline
// a stall at the output freezes every stage; nothing is lost or repeated
// reset (async, active low) clears the stage valid bits and sets damping to 0
module voigt_profile_approx_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] profile_value_o,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i
);

  localparam int unsigned XW  = vpa_pkg::XW;
  localparam int unsigned GW  = vpa_pkg::GW;
  localparam int unsigned DW  = vpa_pkg::DIV_DW;
  localparam int unsigned QW1 = vpa_pkg::DIV_QW1;
  localparam int unsigned QW2 = vpa_pkg::DIV_QW2;
  localparam int unsigned NPOLY = 5;
  localparam int unsigned LAT = 2 + vpa_pkg::GAUSS_LAT + QW1 + NPOLY + QW2 + 4;

  localparam logic [XW-1:0] K_0855 = 31'd896532;
  localparam logic [XW-1:0] K_342  = 31'd3586130;
  localparam logic [XW-1:0] K_21   = 31'd22020096;
  localparam logic [XW-1:0] ONE20  = 31'd1048576;
  localparam logic [26:0]   PK4    = 27'd95193924;
  localparam logic [27:0]   PK3    = 28'd154467828;
  localparam logic [26:0]   PK2    = 27'd74172072;
  localparam logic [20:0]   PK1    = 21'd1874015;
  localparam logic [22:0]   INV_PI24 = 23'd5340354;
  localparam logic [23:0]   OUT_MAX  = 24'hFFFFFF;

  typedef struct packed {
    logic [QW1-1:0] r1;
    logic [XW-1:0]  x;
    logic [GW-1:0]  g;
    logic           low_x;
  } poly_side_t;

  typedef struct packed {
    logic [GW-1:0] g;
    logic [28:0]   pic;
    logic          low_x;
  } tail_side_t;

  logic           en;
  logic [LAT-1:0] v_q;
  logic [23:0]    damping_q;
  logic [15:0]    mag_q;
  logic [XW-1:0]  x_q;
  logic [31:0]    x_prod;

  // gaussian stage outputs
  logic [GW-1:0]  gauss_g;
  logic [XW-1:0]  x_g;
  logic           low_x_g;
  logic [XW-1:0]  a1, ac;

  // first divider pair
  logic [QW1-1:0] quo1, quoc;
  logic [GW+XW-1:0] side1;
  logic           low_x_c;

  // polynomial stages
  poly_side_t     ps_in;
  poly_side_t     ps_q [NPOLY];
  logic [23:0]    p1_c_q, p1_c2_q;
  logic [23:0]    p2_c_q, p2_c2_q, p2_c3_q;
  logic [23:0]    p3_c_q, p3_c2_q, p3_c3_q, p3_c4_q;
  logic [52:0]    m4_q, m3_q, m2_q, m1_q;
  logic [28:0]    pic_q;
  logic [47:0]    sq_c2, sq_c3, sq_c4;
  logic [52:0]    pos_sum;
  logic [28:0]    pos;
  logic [27:0]    neg;

  // second divider and tail
  tail_side_t     ts_in, ts_out;
  logic [QW2-1:0] r2;
  tail_side_t     f1_s_q, f2_s_q;
  logic [26:0]    r3_q, qa_q;
  logic [31:0]    q_q;
  logic [GW-1:0]  g3_q;
  logic [23:0]    out_q;
  logic [50:0]    prod_r3, prod_qa;
  logic [55:0]    prod_q;
  logic [32:0]    sum;

  // whole pipeline advances unless a result waits at the output
  assign en          = ~v_q[LAT-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[LAT-1];
  assign profile_value_o = out_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  // damping register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q <= '0;
    end else if (cfg_we_i) begin
      damping_q <= cfg_wdata_i;
    end
  end

  // magnitude and square of the offset
  assign x_prod = 32'(mag_q) * 32'(mag_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= offset_i[15] ? 16'(~offset_i) + 16'd1 : offset_i;
      x_q   <= x_prod[XW-1:0];
    end
  end

  vpa_gauss #(
    .SW (XW)
  ) u_gauss (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x_q),
    .side_i  (x_q),
    .gauss_o (gauss_g),
    .side_o  (x_g)
  );

  // operands of the two fractional divisions
  always_comb begin
    low_x_g = x_g < K_0855;
    a1      = x_g + K_21;
    ac      = low_x_g ? '0 : x_g - K_0855;
  end

  vpa_div #(
    .DW (DW),
    .QW (QW1),
    .SW (GW + XW)
  ) u_div_r1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (DW'(a1[XW-1:5])),
    .low_i  ({a1[4:0], 24'b0}),
    .den_i  (x_g),
    .side_i ({gauss_g, x_g}),
    .quo_o  (quo1),
    .side_o (side1)
  );

  vpa_div #(
    .DW (DW),
    .QW (QW1),
    .SW (1)
  ) u_div_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (DW'(ac[XW-1:5])),
    .low_i  ({ac[4:0], 24'b0}),
    .den_i  (x_g + K_342),
    .side_i (low_x_g),
    .quo_o  (quoc),
    .side_o (low_x_c)
  );

  // powers of c and the quartic
  always_comb begin
    ps_in.r1    = quo1;
    ps_in.x     = side1[XW-1:0];
    ps_in.g     = side1[GW+XW-1:XW];
    ps_in.low_x = low_x_c;
    sq_c2   = 48'(quoc[23:0]) * 48'(quoc[23:0]);
    sq_c3   = 48'(p1_c2_q) * 48'(p1_c_q);
    sq_c4   = 48'(p2_c3_q) * 48'(p2_c_q);
    pos_sum = m4_q + m2_q + m1_q;
    pos     = pos_sum[52:24];
    neg     = m3_q[51:24];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q[0] <= ps_in;
      for (int i = 1; i < NPOLY; i++) begin
        ps_q[i] <= ps_q[i-1];
      end
      p1_c_q  <= quoc[23:0];
      p1_c2_q <= sq_c2[47:24];
      p2_c_q  <= p1_c_q;
      p2_c2_q <= p1_c2_q;
      p2_c3_q <= sq_c3[47:24];
      p3_c_q  <= p2_c_q;
      p3_c2_q <= p2_c2_q;
      p3_c3_q <= p2_c3_q;
      p3_c4_q <= sq_c4[47:24];
      m4_q    <= 53'(p3_c4_q) * 53'(PK4);
      m3_q    <= 53'(p3_c3_q) * 53'(PK3);
      m2_q    <= 53'(p3_c2_q) * 53'(PK2);
      m1_q    <= 53'(p3_c_q) * 53'(PK1);
      pic_q   <= (pos > 29'(neg)) ? pos - 29'(neg) : '0;
    end
  end

  always_comb begin
    ts_in.g     = ps_q[NPOLY-1].g;
    ts_in.pic   = pic_q;
    ts_in.low_x = ps_q[NPOLY-1].low_x;
  end

  vpa_div #(
    .DW (DW),
    .QW (QW2),
    .SW ($bits(tail_side_t))
  ) u_div_r2 (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (DW'(ps_q[NPOLY-1].r1[QW1-1:8])),
    .low_i  ({ps_q[NPOLY-1].r1[7:0], 20'b0}),
    .den_i  (ps_q[NPOLY-1].x + ONE20),
    .side_i (ts_in),
    .quo_o  (r2),
    .side_o (ts_out)
  );

  // lorentz scaling, damping, sum and saturation
  always_comb begin
    prod_r3 = 51'(r2) * 51'(INV_PI24);
    prod_qa = 51'(r3_q) * 51'(damping_q);
    prod_q  = 56'(qa_q) * 56'(f2_s_q.pic);
    sum     = 33'(q_q) + 33'(g3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r3_q   <= prod_r3[50:24];
      f1_s_q <= ts_out;
      qa_q   <= prod_qa[50:24];
      f2_s_q <= f1_s_q;
      q_q    <= f2_s_q.low_x ? '0 : prod_q[55:24];
      g3_q   <= f2_s_q.g;
      out_q  <= (sum > 33'(OUT_MAX)) ? OUT_MAX : sum[23:0];
    end
  end

endmodule
